### sv/rrast_pkg.sv
// shared types, constants and helpers of the rectangle rasterizer
package rrast_pkg;

  // canvas geometry
  localparam int MAX_SIDE  = 256;
  localparam int FRAC_BITS = 8;
  localparam int SIDE_BITS = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int ADDR_BITS = 2 * SIDE_BITS;
  localparam int DEPTH     = MAX_SIDE * MAX_SIDE;
  localparam int ONE_FIX   = 1 << FRAC_BITS;

  // signed coordinate width: covers cell positions and edge + size sums
  localparam int PX_W    = SIDE_BITS + FRAC_BITS + 1;
  localparam int COORD_W = ((PX_W > 21) ? PX_W : 21) + 1;

  // field widths
  localparam int CFG_W  = 9;
  localparam int CHAR_W = 8;

  // command codes
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_DRAW  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_BG     = 2'd2;

  // shape type characters
  localparam logic [7:0] TYPE_OUTLINE = 8'h72;
  localparam logic [7:0] TYPE_FILLED  = 8'h52;

  // reset values of the configuration registers
  localparam logic [CFG_W-1:0]  WIDTH_RST  = 9'd256;
  localparam logic [CFG_W-1:0]  HEIGHT_RST = 9'd256;
  localparam logic [CHAR_W-1:0] BG_RST     = 8'd32;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [19:0] rect_left;
    logic signed [19:0] rect_top;
    logic [18:0]        rect_width;
    logic [18:0]        rect_height;
    logic [7:0]         shape_type;
    logic [7:0]         paint_char;
    logic [7:0]         read_col;
    logic [7:0]         read_row;
  } in_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic       status;
  } out_t;

  // rectangle box in cell-space fixed point
  typedef struct packed {
    logic signed [COORD_W-1:0] tx;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] ty;
    logic signed [COORD_W-1:0] by;
    logic                      filled;
  } geom_t;

  // last usable index of a side: zero acts as one, large values clamp
  function automatic logic [SIDE_BITS-1:0] side_last(input logic [CFG_W-1:0] v);
    logic [SIDE_BITS-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (int'(v) > MAX_SIDE) begin
      r = SIDE_BITS'(MAX_SIDE - 1);
    end else begin
      r = SIDE_BITS'(v - 9'd1);
    end
    return r;
  endfunction

endpackage

### sv/rect_outline_fill_rasterizer_top.sv
// top level of the rectangle rasterizer: sequencer, config registers, canvas
//
//   channel | signals                          | transfer when
//   --------+----------------------------------+--------------------------
//   in      | in_valid, in_stall, in_data      | in_valid && !in_stall
//   out     | out_valid, out_stall, out_data   | out_valid && !out_stall
//   cfg     | cfg_we, cfg_index, cfg_data      | cfg_we
//
// clear and draw sweep the canvas in use one cell per cycle through the
// single canvas ram port. read passes through the address, ram data and
// result states; a rejected draw and command 3 go straight to the result
// state. one item is in work at a time; in_stall is high until it is
// finished. the result register lets a new item start while the previous
// result waits; a finished item holds until that register frees.
// rst clears control state and config; the canvas is undefined until cleared.
module rect_outline_fill_rasterizer_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  rrast_pkg::in_t                in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output rrast_pkg::out_t               out_data,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [rrast_pkg::CFG_W-1:0]   cfg_data
);
  import rrast_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RDADDR,
    S_RDDATA,
    S_DONE
  } state_t;

  state_t                state;
  in_t                   item;
  geom_t                 geom;
  logic                  clearing;
  logic [SIDE_BITS-1:0]  scan_col;
  logic [SIDE_BITS-1:0]  scan_row;
  out_t                  res;

  logic [CFG_W-1:0]      canvas_width;
  logic [CFG_W-1:0]      canvas_height;
  logic [CHAR_W-1:0]     background_char;

  logic [SIDE_BITS-1:0]  w_last;
  logic [SIDE_BITS-1:0]  h_last;
  logic                  hit;
  logic                  in_take;
  logic                  out_free;
  logic                  draw_bad;
  logic                  read_inside;
  logic                  ram_we;
  logic [ADDR_BITS-1:0]  ram_addr;
  logic [CHAR_W-1:0]     ram_wdata;
  logic [CHAR_W-1:0]     ram_rdata;

  // canvas extent in use
  assign w_last = side_last(canvas_width);
  assign h_last = side_last(canvas_height);

  // handshakes
  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // draw rejection
  assign draw_bad = (int'(in_data.rect_width) < ONE_FIX)
                 || (int'(in_data.rect_height) < ONE_FIX)
                 || ((in_data.shape_type != TYPE_OUTLINE)
                     && (in_data.shape_type != TYPE_FILLED));

  // read position inside the canvas in use
  assign read_inside = (int'(item.read_col) <= int'(w_last))
                    && (int'(item.read_row) <= int'(h_last));

  // per-cell compare unit
  rrast_cell u_cell (
    .col  (scan_col),
    .row  (scan_row),
    .geom (geom),
    .hit  (hit)
  );

  // canvas port: sweep writes during scan, cell address during read
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = {scan_row, scan_col};
    ram_wdata = clearing ? background_char : item.paint_char;
    if (state == S_SCAN) begin
      ram_we = clearing || hit;
    end else if (state == S_RDADDR || state == S_RDDATA) begin
      ram_addr = {SIDE_BITS'(item.read_row), SIDE_BITS'(item.read_col)};
    end
  end

  rrast_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (DEPTH)
  ) u_canvas (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width    <= WIDTH_RST;
      canvas_height   <= HEIGHT_RST;
      background_char <= BG_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  canvas_width    <= cfg_data;
        CFG_HEIGHT: canvas_height   <= cfg_data;
        CFG_BG:     background_char <= cfg_data[CHAR_W-1:0];
        default:    ;
      endcase
    end
  end

  // sequencer with result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      scan_col  <= '0;
      scan_row  <= '0;
      out_valid <= 1'b0;
      clearing  <= 1'b0;
    end else begin
      // result register: load a finished item, or drop a taken result
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
        out_data  <= res;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            item     <= in_data;
            res      <= '{cell_char: '0,
                          status: (in_data.cmd == CMD_DRAW) && draw_bad};
            scan_col <= '0;
            scan_row <= '0;
            geom.tx     <= COORD_W'(in_data.rect_left);
            geom.ty     <= COORD_W'(in_data.rect_top);
            geom.bx     <= COORD_W'(in_data.rect_left) + COORD_W'(in_data.rect_width);
            geom.by     <= COORD_W'(in_data.rect_top) + COORD_W'(in_data.rect_height);
            geom.filled <= (in_data.shape_type == TYPE_FILLED);
            clearing    <= (in_data.cmd == CMD_CLEAR);
            case (in_data.cmd)
              CMD_CLEAR: state <= S_SCAN;
              CMD_DRAW: begin
                if (draw_bad) begin
                  state <= S_DONE;
                end else begin
                  state <= S_SCAN;
                end
              end
              CMD_READ: state <= S_RDADDR;
              default:  state <= S_DONE;
            endcase
          end
        end
        // one cell per cycle, row by row
        S_SCAN: begin
          if (scan_col == w_last) begin
            scan_col <= '0;
            if (scan_row == h_last) begin
              scan_row <= '0;
              state    <= S_DONE;
            end else begin
              scan_row <= scan_row + 1'b1;
            end
          end else begin
            scan_col <= scan_col + 1'b1;
          end
        end
        S_RDADDR: begin
          state <= S_RDDATA;
        end
        S_RDDATA: begin
          res.cell_char <= read_inside ? ram_rdata : '0;
          state         <= S_DONE;
        end
        // hand the result over once the result register is free
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/rrast_ram.sv
// generic single-port ram with registered read
module rrast_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### sv/rrast_cell.sv
// compare unit: decides whether one canvas cell is painted by the rectangle
module rrast_cell (
  input  logic [rrast_pkg::SIDE_BITS-1:0] col,
  input  logic [rrast_pkg::SIDE_BITS-1:0] row,
  input  rrast_pkg::geom_t                geom,
  output logic                            hit
);
  import rrast_pkg::*;

  logic signed [COORD_W-1:0] px;
  logic signed [COORD_W-1:0] py;
  logic signed [COORD_W-1:0] dx_lo;
  logic signed [COORD_W-1:0] dx_hi;
  logic signed [COORD_W-1:0] dy_lo;
  logic signed [COORD_W-1:0] dy_hi;
  logic signed [COORD_W-1:0] one;
  logic                      covered;
  logic                      band;

  // cell position in fixed point
  assign px  = COORD_W'(col) <<< FRAC_BITS;
  assign py  = COORD_W'(row) <<< FRAC_BITS;
  assign one = COORD_W'(ONE_FIX);

  // distances to the left, right, top and bottom edges
  assign dx_lo = px - geom.tx;
  assign dx_hi = geom.bx - px;
  assign dy_lo = py - geom.ty;
  assign dy_hi = geom.by - py;

  // inside the closed box, and within one unit of an edge
  assign covered = (dx_lo >= 0) && (dx_hi >= 0) && (dy_lo >= 0) && (dy_hi >= 0);
  assign band    = (dx_lo < one) || (dx_hi < one) || (dy_lo < one) || (dy_hi < one);
  assign hit     = covered && (band || geom.filled);

endmodule

### sim/rect_outline_fill_rasterizer_top_test.sv
// self-checking testbench of the rectangle rasterizer: canvas prediction and result checks
module rect_outline_fill_rasterizer_top_test;
  import rrast_pkg::*;

  // command 3 has no meaning and must answer zero
  localparam logic [1:0] CMD_NONE     = 2'd3;
  localparam logic [7:0] TYPE_UNKNOWN = 8'h78;

  logic            clk       = 1'b0;
  logic            rst       = 1'b1;
  logic            in_valid  = 1'b0;
  logic            in_stall;
  in_t             in_data   = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  out_t            out_data;
  logic            cfg_we    = 1'b0;
  logic [1:0]      cfg_index = CFG_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;

  // predicted canvas and register copies
  logic [7:0]       canvas_img [0:DEPTH-1];
  logic [CFG_W-1:0] cols_reg = WIDTH_RST;
  logic [CFG_W-1:0] rows_reg = HEIGHT_RST;
  logic [7:0]       bg_reg   = BG_RST;

  out_t expected_cells[$];
  int   mismatch_count = 0;
  int   stall_left     = 0;
  bit   gaps_on        = 1'b1;
  int   n_clear = 0, n_draw = 0, n_reject = 0, n_read = 0, n_unused = 0;

  rect_outline_fill_rasterizer_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // size register as the block uses it: zero acts as one, large values clamp
  function automatic int side_in_use(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_SIDE) return MAX_SIDE;
    return int'(v);
  endfunction

  // apply one command to the predicted canvas and return its result
  function automatic out_t predict_raster(input in_t item);
    out_t   res;
    int     w, h;
    longint tx, ty, bx, by, px, py;
    bit     hit, band;
    res = '0;
    w = side_in_use(cols_reg);
    h = side_in_use(rows_reg);
    case (item.cmd)
      CMD_CLEAR: begin
        n_clear++;
        for (int r = 0; r < h; r++)
          for (int c = 0; c < w; c++)
            canvas_img[r * MAX_SIDE + c] = bg_reg;
      end
      CMD_DRAW: begin
        n_draw++;
        if (item.rect_width < ONE_FIX || item.rect_height < ONE_FIX ||
            (item.shape_type != TYPE_OUTLINE && item.shape_type != TYPE_FILLED)) begin
          n_reject++;
          res.status = 1'b1;
        end else begin
          tx = $signed(item.rect_left);
          ty = $signed(item.rect_top);
          bx = item.rect_width;
          by = item.rect_height;
          bx = tx + bx;
          by = ty + by;
          for (int r = 0; r < h; r++) begin
            for (int c = 0; c < w; c++) begin
              px = longint'(c) * ONE_FIX;
              py = longint'(r) * ONE_FIX;
              hit = (px >= tx && px <= bx && py >= ty && py <= by);
              band = (px - tx < ONE_FIX || bx - px < ONE_FIX ||
                      py - ty < ONE_FIX || by - py < ONE_FIX);
              if (hit && (band || item.shape_type == TYPE_FILLED))
                canvas_img[r * MAX_SIDE + c] = item.paint_char;
            end
          end
        end
      end
      CMD_READ: begin
        n_read++;
        if (item.read_col < w && item.read_row < h)
          res.cell_char = canvas_img[item.read_row * MAX_SIDE + item.read_col];
      end
      default: begin
        n_unused++;
      end
    endcase
    return res;
  endfunction

  // command builders: fields the command ignores carry random bits
  function automatic in_t noise_cmd();
    logic [127:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom};
    return bits[$bits(in_t)-1:0];
  endfunction

  function automatic in_t plain_cmd(input logic [1:0] code);
    in_t item;
    item = noise_cmd();
    item.cmd = code;
    return item;
  endfunction

  function automatic in_t read_cmd(input int col, input int row);
    in_t item;
    item = plain_cmd(CMD_READ);
    item.read_col = col[7:0];
    item.read_row = row[7:0];
    return item;
  endfunction

  function automatic in_t draw_cmd(input int left, input int top, input int w, input int h,
                                   input logic [7:0] shape, input logic [7:0] paint);
    in_t item;
    item = plain_cmd(CMD_DRAW);
    item.rect_left   = left[19:0];
    item.rect_top    = top[19:0];
    item.rect_width  = w[18:0];
    item.rect_height = h[18:0];
    item.shape_type  = shape;
    item.paint_char  = paint;
    return item;
  endfunction

  // cell near a left/top edge, a right/bottom edge or the middle of a span
  function automatic int near_edge(input int lo, input int span);
    int base;
    case ($urandom_range(0, 2))
      0: base = lo >>> FRAC_BITS;
      1: base = (lo + span) >>> FRAC_BITS;
      default: base = (lo + span / 2) >>> FRAC_BITS;
    endcase
    base = base + int'($urandom_range(0, 2)) - 1;
    if (base < 0 || base > 255) base = int'($urandom_range(0, 255));
    return base;
  endfunction

  // one input transfer, with an optional gap before it
  task automatic push_command(input in_t item);
    int gap;
    gap = (gaps_on && $urandom_range(0, 3) == 0) ? int'($urandom_range(1, 8)) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_cells.push_back(predict_raster(item));
  endtask

  // stop sending and wait for every pending result
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
  endtask

  // write enable is left high; configure lowers it after the last write
  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_WIDTH:  cols_reg = val;
      CFG_HEIGHT: rows_reg = val;
      CFG_BG:     bg_reg = val[7:0];
      default: ;
    endcase
  endtask

  // registers change only with the block idle
  task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                           input logic [7:0] bg);
    drain();
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_BG, {1'($urandom), bg});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // full-size clear with all fields zero, so every cell is defined afterwards
  task automatic test_clear_full();
    push_command('0);
    push_command(read_cmd(0, 0));
    push_command(read_cmd(255, 255));
  endtask

  // sizes under one unit and unknown types leave the canvas alone
  task automatic test_rejects();
    push_command(draw_cmd(256, 256, 255, 512, TYPE_FILLED, 8'($urandom)));
    push_command(draw_cmd(256, 256, 512, 0, TYPE_OUTLINE, 8'($urandom)));
    push_command(draw_cmd(0, 0, 1024, 1024, TYPE_UNKNOWN, 8'($urandom)));
    push_command(draw_cmd(0, 0, 1024, 1024, '0, 8'($urandom)));
    push_command(read_cmd(1, 1));
    // all ones is the unused command
    push_command('1);
  endtask

  // outline band one unit wide on each side, interior untouched
  task automatic test_outline();
    push_command(draw_cmd(256, 256, 5 * 256, 5 * 256, TYPE_OUTLINE, 8'($urandom)));
    push_command(read_cmd(1, 1));
    push_command(read_cmd(3, 3));
    push_command(read_cmd(6, 6));
  endtask

  // fractional edges, part of the box left of the canvas
  task automatic test_filled();
    push_command(draw_cmd(-128, 576, 768, 256, TYPE_FILLED, 8'($urandom)));
    push_command(read_cmd(2, 3));
    push_command(read_cmd(3, 3));
  endtask

  // field extremes: box entirely off canvas, read outside the canvas in use
  task automatic test_field_extremes();
    push_command(draw_cmd(524287, -524288, 524287, 524287, TYPE_FILLED, '1));
    push_command(draw_cmd(-524288, -524288, 524287, 524287, TYPE_OUTLINE, '0));
    push_command(read_cmd(255, 255));
  endtask

  // size registers at zero, at the top and above the top
  task automatic test_canvas_size();
    configure(9'd0, 9'd511, 8'h00);
    push_command(plain_cmd(CMD_CLEAR));
    push_command(read_cmd(0, 200));
    push_command(read_cmd(1, 0));
    configure(9'd511, 9'd0, 8'hFF);
    push_command(draw_cmd(-256, -128, 300 * 256, 256, TYPE_FILLED, 8'($urandom)));
    push_command(read_cmd(255, 0));
    push_command(read_cmd(10, 1));
    configure(9'd256, 9'd511, 8'($urandom));
    push_command(draw_cmd(128, 128, 254 * 256, 254 * 256, TYPE_OUTLINE, 8'($urandom)));
    push_command(read_cmd(254, 1));
    push_command(read_cmd(128, 128));
  endtask

  // one setting: mostly draws followed by reads around their edges, plus noise
  task automatic run_phase(input int cols, input int rows, input int count);
    int  sent, pick, left, top, span_x, span_y, nreads;
    in_t item;
    configure(cols[CFG_W-1:0], rows[CFG_W-1:0], 8'($urandom));
    push_command(plain_cmd(CMD_CLEAR));
    sent = 1;
    while (sent < count) begin
      pick = int'($urandom_range(0, 99));
      if (pick < 60) begin
        left   = int'($urandom_range(0, (cols + 4) * 256)) - 512;
        top    = int'($urandom_range(0, (rows + 4) * 256)) - 512;
        span_x = int'($urandom_range(256, (cols + 2) * 256));
        span_y = int'($urandom_range(256, (rows + 2) * 256));
        push_command(draw_cmd(left, top, span_x, span_y,
                              $urandom_range(0, 1) ? TYPE_FILLED : TYPE_OUTLINE,
                              8'($urandom)));
        nreads = int'($urandom_range(1, 3));
        for (int k = 0; k < nreads; k++)
          push_command(read_cmd(near_edge(left, span_x), near_edge(top, span_y)));
        sent += 1 + nreads;
      end else if (pick < 66) begin
        // draw with small sizes and a random type: mostly broken, too small or a wrong type
        item = draw_cmd(int'($urandom_range(0, cols * 256)), int'($urandom_range(0, rows * 256)),
                        int'($urandom_range(0, 300)), int'($urandom_range(0, 300)),
                        8'($urandom), 8'($urandom));
        push_command(item);
        sent++;
      end else if (pick < 72) begin
        push_command(plain_cmd(CMD_DRAW));
        sent++;
      end else if (pick < 80) begin
        push_command(plain_cmd(CMD_CLEAR));
        sent++;
      end else if (pick < 94) begin
        push_command(read_cmd(int'($urandom_range(0, 255)), int'($urandom_range(0, 255))));
        sent++;
      end else begin
        push_command(plain_cmd(CMD_NONE));
        sent++;
      end
    end
  endtask

  task automatic test_random_traffic();
    run_phase(int'($urandom_range(2, 16)), int'($urandom_range(2, 16)), 20);
    run_phase(1, int'($urandom_range(8, 24)), 20);
    run_phase(int'($urandom_range(8, 32)), int'($urandom_range(1, 4)), 20);
    // last stretch with no idling on either side
    drain();
    gaps_on = 1'b0;
    run_phase(int'($urandom_range(4, 16)), int'($urandom_range(4, 16)), 20);
  endtask

  // result stall in random bursts
  always @(negedge clk) begin
    if (!gaps_on) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= ($urandom_range(0, 2) == 0);
      stall_left <= int'($urandom_range(1, 8));
    end
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_cells.size() == 0) begin
        $error("result with nothing pending: cell_char %0d status %0d",
               out_data.cell_char, out_data.status);
        mismatch_count++;
      end else begin
        want = expected_cells.pop_front();
        if (out_data.cell_char !== want.cell_char) begin
          $error("cell_char: expected %0d, got %0d", want.cell_char, out_data.cell_char);
          mismatch_count++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_clear_full();
    configure(9'd8, 9'd8, 8'($urandom));
    test_rejects();
    test_outline();
    test_filled();
    test_field_extremes();
    test_canvas_size();
    test_random_traffic();
    drain();
    repeat (10) @(posedge clk);
    if (expected_cells.size() != 0) begin
      $error("%0d results never arrived", expected_cells.size());
      mismatch_count++;
    end
    $display("covered %0d clears, %0d draws (%0d rejected), %0d reads, %0d unused commands",
             n_clear, n_draw, n_reject, n_read, n_unused);
    $display("canvas sizes from one cell up to the full side, with sender gaps and result stalls");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
